>>> hw/rtl/smx_pkg.sv
// smx_pkg: shared types and constants of the stack machine executor
// command codes, sequencer states, control and status bundles
// used by smx_ctrl, smx_dpath and stack_machine_executor
package smx_pkg;

  // default number of stack entries
  localparam int DEF_STACK_DEPTH = 16;

  // field widths fixed by the interface
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 64;
  localparam int DEPTH_W = 5;

  // instruction codes, the rest are no-ops
  localparam logic [CMD_W-1:0] BC_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] BC_PRINT  = 3'd1;
  localparam logic [CMD_W-1:0] BC_READ   = 3'd2;
  localparam logic [CMD_W-1:0] BC_IADD   = 3'd3;
  localparam logic [CMD_W-1:0] BC_STOP   = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD2,
    ST_DONE
  } smx_state_t;

  // strobes from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic add2;
    logic load_out;
  } smx_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             level_zero;
    logic             level_one;
    logic             out_free;
  } smx_sts_t;

endpackage

>>> hw/rtl/stack_machine_executor.sv
// stack_machine_executor: top level of the stack machine executor
// joins the sequencer smx_ctrl and the datapath smx_dpath
// depends on smx_pkg
//
//  channel  dir  tdata                                      tuser        tlast
//  s_*      in   argument[63:0] read_value[127:64]          command[2:0] -
//  m_*      out  print_value[63:0] push_dropped[64]         print_valid  finished
//                depth_now[69:65] zero[71:70]
//
// an instruction passes through accept, execute and result load, with a
// second operand step before the load for an add on two or more entries;
// the single registered read port of the stack memory sets this, as add
// fetches its two operands one after the other
// reset empties the stack by clearing the level; the store is not cleared
// a result waits in the sequencer while the output register holds an untaken
// beat; the next instruction is accepted while that beat waits
module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // argument[63:0], read_value[127:64]
  input  logic [2:0]    s_tuser,   // command[2:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata,   // print_value[63:0], push_dropped[64],
                                   // depth_now[69:65], zero fill[71:70]
  output logic          m_tuser,   // print_valid
  output logic          m_tlast    // finished
);
  import smx_pkg::*;

  smx_ctl_t ctl;
  smx_sts_t sts;

  logic signed [DATA_W-1:0] print_value;
  logic                     push_dropped;
  logic [DEPTH_W-1:0]       depth_now;

  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  smx_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (s_tuser),
    .in_argument      (s_tdata[63:0]),
    .in_read_value    (s_tdata[127:64]),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_print_valid  (m_tuser),
    .out_print_value  (print_value),
    .out_push_dropped (push_dropped),
    .out_depth_now    (depth_now),
    .out_finished     (m_tlast)
  );

  // pack result beat
  assign m_tdata = {2'b00, depth_now, push_dropped, print_value};

endmodule

>>> hw/rtl/smx_ctrl.sv
// smx_ctrl: instruction sequencer of the stack machine executor
// walks capture, execute, second operand fetch and result hand-off
// depends on smx_pkg
module smx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  smx_pkg::smx_sts_t sts,
  output smx_pkg::smx_ctl_t ctl
);
  import smx_pkg::*;

  smx_state_t state;
  smx_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // add with two or more entries needs the second operand
        if (sts.cmd == BC_IADD && !sts.level_zero && !sts.level_one) begin
          state_next = ST_ADD2;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ADD2: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready     = 1'b0;
    ctl          = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        ctl.capture = s_tvalid;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_ADD2: begin
        ctl.add2 = 1'b1;
      end
      ST_DONE: begin
        ctl.load_out = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/smx_dpath.sv
// smx_dpath: stack memory, level counter, adder and output register
// acts on strobes from smx_ctrl and reports command and level status
// depends on smx_pkg
module smx_dpath #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  smx_pkg::smx_ctl_t                ctl,
  output smx_pkg::smx_sts_t                sts,
  input  logic [smx_pkg::CMD_W-1:0]        in_command,
  input  logic signed [smx_pkg::DATA_W-1:0] in_argument,
  input  logic signed [smx_pkg::DATA_W-1:0] in_read_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_print_valid,
  output logic signed [smx_pkg::DATA_W-1:0] out_print_value,
  output logic                             out_push_dropped,
  output logic [smx_pkg::DEPTH_W-1:0]      out_depth_now,
  output logic                             out_finished
);
  import smx_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  // stack store and level
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [LW-1:0]     level;
  logic [LW-1:0]     level_next;
  logic [LW-1:0]     lvl_m1;
  logic [LW-1:0]     lvl_m2;
  logic              full;

  // captured instruction and operands
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] a_q;

  // memory port controls
  logic              re;
  logic [AW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  // staged result
  logic              res_pv;
  logic [DATA_W-1:0] res_pval;
  logic              res_drop;
  logic              res_fin;
  logic [LW+DEPTH_W-1:0] depth_ext;

  assign lvl_m1 = level - LW'(1);
  assign lvl_m2 = level - LW'(2);
  assign full   = (level == LW'(STACK_DEPTH));

  assign sts.cmd        = cmd_q;
  assign sts.level_zero = (level == '0);
  assign sts.level_one  = (level == LW'(1));
  assign sts.out_free   = !out_valid || out_ready;

  // memory reads: top on capture, second entry for add
  always_comb begin
    re = 1'b0;
    ra = lvl_m1[AW-1:0];
    if (ctl.capture && level != '0) begin
      re = 1'b1;
    end else if (ctl.exec && cmd_q == BC_IADD && level > LW'(1)) begin
      re = 1'b1;
      ra = lvl_m2[AW-1:0];
    end
  end

  // memory writes: push or read into free slot, add sum over second entry
  always_comb begin
    we = 1'b0;
    wa = level[AW-1:0];
    wd = val_q;
    if (ctl.exec && (cmd_q == BC_PUSH || cmd_q == BC_READ) && !full) begin
      we = 1'b1;
    end else if (ctl.add2) begin
      we = 1'b1;
      wa = lvl_m2[AW-1:0];
      wd = a_q + rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (re) rd_q <= mem[ra];
  end

  // level update
  always_comb begin
    level_next = level;
    if (ctl.exec) begin
      unique case (cmd_q)
        BC_PUSH, BC_READ: begin
          if (!full) level_next = level + LW'(1);
        end
        BC_PRINT: begin
          if (level != '0) level_next = lvl_m1;
        end
        BC_STOP: begin
          level_next = '0;
        end
        default: begin
          level_next = level;
        end
      endcase
    end else if (ctl.add2) begin
      level_next = lvl_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  // capture instruction and operands
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= in_command;
      val_q <= (in_command == BC_READ) ? in_read_value : in_argument;
    end
    if (ctl.exec) a_q <= rd_q;
  end

  // stage result flags at execute
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_pv   <= (cmd_q == BC_PRINT) && (level != '0);
      res_pval <= ((cmd_q == BC_PRINT) && (level != '0)) ? rd_q : '0;
      res_drop <= (cmd_q == BC_PUSH || cmd_q == BC_READ) && full;
      res_fin  <= (cmd_q == BC_STOP);
    end
  end

  assign depth_ext = (LW + DEPTH_W)'(level);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_print_valid  <= res_pv;
      out_print_value  <= res_pval;
      out_push_dropped <= res_drop;
      out_depth_now    <= depth_ext[DEPTH_W-1:0];
      out_finished     <= res_fin;
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(STACK_DEPTH))
    else $error("stack level above depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending beat");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && full && (cmd_q == BC_PUSH || cmd_q == BC_READ) |=> level == $past(level))
    else $error("level changed on dropped push");

  a_add2_level: assert property (@(posedge clk) disable iff (rst)
    ctl.add2 |-> level > LW'(1) ##1 level == $past(lvl_m1))
    else $error("add second step with wrong level");
`endif

endmodule
